[rtl/assert_macros.svh]
// Assertion macros for the RTL of the gamepad event state tracker.
// Depends on nothing; files that assert include it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/ges_pkg.sv]
// Package of the gamepad event state tracker: payload, configuration and state types,
// event and register codes, reset values and position constants. Depends on nothing.
`timescale 1ns / 1ps

package ges_pkg;

  localparam int BUTTON_COUNT = 32;
  localparam int BUTTON_LIMIT = (BUTTON_COUNT < 32) ? BUTTON_COUNT : 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [1:0] FUNC_BUTTON = 2'd0;
  localparam logic [1:0] FUNC_PAD    = 2'd1;
  localparam logic [1:0] FUNC_HAT    = 2'd2;
  localparam logic [1:0] FUNC_AXIS   = 2'd3;

  localparam logic [5:0] AXIS_X  = 6'd0;
  localparam logic [5:0] AXIS_Y  = 6'd1;
  localparam logic [5:0] AXIS_LT = 6'd2;
  localparam logic [5:0] AXIS_RT = 6'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_ON      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_OFF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_GAMEPAD        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEFT_BIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_RIGHT_BIT = 3'd4;

  localparam logic [14:0] RST_THRESHOLD_ON      = 15'd16384;
  localparam logic [14:0] RST_THRESHOLD_OFF     = 15'd8192;
  localparam logic        RST_IS_GAMEPAD        = 1'b1;
  localparam logic [4:0]  RST_TRIGGER_LEFT_BIT  = 5'd16;
  localparam logic [4:0]  RST_TRIGGER_RIGHT_BIT = 5'd17;

  localparam logic [15:0] POS_MIN = 16'h0000;
  localparam logic [15:0] POS_MID = 16'h7FFF;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         event_index;
    logic               pressed;
    logic signed [15:0] axis_value;
    logic [3:0]         hat_bits;
    logic               clear_active;
  } ges_in_t;

  typedef struct packed {
    logic [31:0]        button_bits;
    logic [3:0]         pad_bits;
    logic [15:0]        x_position;
    logic [15:0]        y_position;
    logic signed [15:0] stick_x_out;
    logic signed [15:0] stick_y_out;
    logic               press_event;
    logic               release_event;
    logic [4:0]         event_button;
    logic               activity;
  } ges_out_t;

  typedef struct packed {
    logic [14:0] threshold_on;
    logic [14:0] threshold_off;
    logic        is_gamepad;
    logic [4:0]  trigger_left_bit;
    logic [4:0]  trigger_right_bit;
  } ges_cfg_t;

  typedef struct packed {
    logic [31:0] button_store;
    logic [3:0]  digital_pad;
    logic [3:0]  analog_pad;
    logic [3:0]  current_pad;
    logic [15:0] stick_x_store;
    logic [15:0] stick_y_store;
    logic        active_store;
  } ges_state_t;

endpackage

[rtl/ges_cfg_regs.sv]
// Configuration register file of the gamepad event state tracker.
// Depends on ges_pkg for the register codes, reset values and the configuration struct.
`timescale 1ns / 1ps

module ges_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ges_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ges_pkg::CFG_DATA_W-1:0] cfg_data,
  output ges_pkg::ges_cfg_t              cfg
);

  ges_pkg::ges_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_on      <= ges_pkg::RST_THRESHOLD_ON;
      cfg_r.threshold_off     <= ges_pkg::RST_THRESHOLD_OFF;
      cfg_r.is_gamepad        <= ges_pkg::RST_IS_GAMEPAD;
      cfg_r.trigger_left_bit  <= ges_pkg::RST_TRIGGER_LEFT_BIT;
      cfg_r.trigger_right_bit <= ges_pkg::RST_TRIGGER_RIGHT_BIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ges_pkg::CFG_THRESHOLD_ON:      cfg_r.threshold_on      <= cfg_data[14:0];
        ges_pkg::CFG_THRESHOLD_OFF:     cfg_r.threshold_off     <= cfg_data[14:0];
        ges_pkg::CFG_IS_GAMEPAD:        cfg_r.is_gamepad        <= cfg_data[0];
        ges_pkg::CFG_TRIGGER_LEFT_BIT:  cfg_r.trigger_left_bit  <= cfg_data[4:0];
        ges_pkg::CFG_TRIGGER_RIGHT_BIT: cfg_r.trigger_right_bit <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/ges_event_logic.sv]
// Combinational event handling: next tracker state and the result of one event.
// Depends on ges_pkg for the payload, configuration and state types and the event codes.
`timescale 1ns / 1ps

module ges_event_logic (
  input  ges_pkg::ges_in_t    item,
  input  ges_pkg::ges_cfg_t   cfg,
  input  ges_pkg::ges_state_t state,
  output ges_pkg::ges_state_t state_nxt,
  output ges_pkg::ges_out_t   result
);

  ges_pkg::ges_state_t st;
  logic signed [16:0]  v17;
  logic signed [16:0]  negv17;
  logic signed [16:0]  on17;
  logic signed [16:0]  off17;
  logic [3:0]          dig_new;
  logic [3:0]          ana_new;
  logic [4:0]          trig_bit;
  logic                trig_old;
  logic                trig_new;
  logic                rep_press;
  logic                rep_release;
  logic [4:0]          rep_button;

  function automatic logic hyst(input logic signed [16:0] v, input logic old,
                                input logic signed [16:0] on_t,
                                input logic signed [16:0] off_t);
    return old ? (v >= off_t) : (v >= on_t);
  endfunction

  assign v17    = {item.axis_value[15], item.axis_value};
  assign negv17 = -v17;
  assign on17   = $signed({2'b00, cfg.threshold_on});
  assign off17  = $signed({2'b00, cfg.threshold_off});

  always_comb begin
    st          = state;
    dig_new     = state.digital_pad;
    ana_new     = state.analog_pad;
    trig_bit    = cfg.trigger_left_bit;
    trig_old    = 1'b0;
    trig_new    = 1'b0;
    rep_press   = 1'b0;
    rep_release = 1'b0;
    rep_button  = 5'd0;
    unique case (item.func)
      ges_pkg::FUNC_BUTTON: begin
        if (int'(item.event_index) < ges_pkg::BUTTON_LIMIT) begin
          st.button_store[item.event_index[4:0]] = item.pressed;
          if (item.pressed) st.active_store = 1'b1;
          rep_press   = item.pressed;
          rep_release = !item.pressed;
          rep_button  = item.event_index[4:0];
        end
      end
      ges_pkg::FUNC_PAD: begin
        if (item.event_index[5:2] == 4'd0) begin
          dig_new[item.event_index[1:0]] = item.pressed;
          if (dig_new != state.digital_pad) begin
            st.digital_pad = dig_new;
            st.current_pad = dig_new;
            if (item.pressed) st.active_store = 1'b1;
          end
        end
      end
      ges_pkg::FUNC_HAT: begin
        if (!cfg.is_gamepad) begin
          dig_new = {item.hat_bits[1], item.hat_bits[3], item.hat_bits[2], item.hat_bits[0]};
          if (dig_new != state.digital_pad) begin
            st.digital_pad = dig_new;
            st.current_pad = dig_new;
            if ((dig_new & ~state.digital_pad) != 4'd0) st.active_store = 1'b1;
          end
        end
      end
      ges_pkg::FUNC_AXIS: begin
        unique case (item.event_index)
          ges_pkg::AXIS_X: begin
            if (cfg.is_gamepad) st.stick_x_store = item.axis_value;
            ana_new[3] = hyst(v17, state.analog_pad[3], on17, off17);
            ana_new[2] = hyst(negv17, state.analog_pad[2], on17, off17);
          end
          ges_pkg::AXIS_Y: begin
            if (cfg.is_gamepad) st.stick_y_store = item.axis_value;
            ana_new[1] = hyst(v17, state.analog_pad[1], on17, off17);
            ana_new[0] = hyst(negv17, state.analog_pad[0], on17, off17);
          end
          ges_pkg::AXIS_LT, ges_pkg::AXIS_RT: begin
            if (item.event_index == ges_pkg::AXIS_RT) trig_bit = cfg.trigger_right_bit;
            trig_old = state.button_store[trig_bit];
            trig_new = hyst(v17, trig_old, on17, off17);
            if (cfg.is_gamepad && (trig_new != trig_old) &&
                (int'(trig_bit) < ges_pkg::BUTTON_LIMIT)) begin
              st.button_store[trig_bit] = trig_new;
              if (trig_new) st.active_store = 1'b1;
              rep_press   = trig_new;
              rep_release = !trig_new;
              rep_button  = trig_bit;
            end
          end
          default: begin
          end
        endcase
        if (ana_new != state.analog_pad) begin
          st.analog_pad  = ana_new;
          st.current_pad = ana_new;
          if ((ana_new & ~state.analog_pad) != 4'd0) st.active_store = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    result.button_bits   = st.button_store;
    result.pad_bits      = st.current_pad;
    result.stick_x_out   = st.stick_x_store;
    result.stick_y_out   = st.stick_y_store;
    result.press_event   = rep_press;
    result.release_event = rep_release;
    result.event_button  = rep_button;
    result.activity      = st.active_store;
    unique case (st.current_pad[3:2])
      2'b01:   result.x_position = ges_pkg::POS_MIN;
      2'b10:   result.x_position = ges_pkg::POS_MAX;
      default: result.x_position = ges_pkg::POS_MID;
    endcase
    unique case (st.current_pad[1:0])
      2'b01:   result.y_position = ges_pkg::POS_MIN;
      2'b10:   result.y_position = ges_pkg::POS_MAX;
      default: result.y_position = ges_pkg::POS_MID;
    endcase
    state_nxt = st;
    if (item.clear_active) state_nxt.active_store = 1'b0;
  end

endmodule

[rtl/gamepad_event_state_tracker.sv]
// Top level of the gamepad event state tracker: input register, state, result register.
// Depends on ges_pkg, ges_cfg_regs, ges_event_logic and assert_macros.svh.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall   ges_pkg::ges_in_t   in_data
//   out_      output     out_valid / out_stall ges_pkg::ges_out_t  out_data
//   cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An event's result is offered after its transfer, once the result register loads it.
// One event is taken every cycle while the output is not stalled.
// Reset clears the tracker state and the valid flags and loads the default configuration.
// A stalled output holds its result; the input register still takes one more event if empty.
// Configuration writes are always ready and take effect on the next cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gamepad_event_state_tracker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ges_pkg::ges_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ges_pkg::ges_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ges_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ges_pkg::CFG_DATA_W-1:0] cfg_data
);

  ges_pkg::ges_cfg_t   cfg;
  ges_pkg::ges_in_t    item_r;
  logic                item_valid_r;
  logic                item_valid_nxt;
  ges_pkg::ges_state_t state_r;
  ges_pkg::ges_state_t state_nxt;
  ges_pkg::ges_out_t   result;
  ges_pkg::ges_out_t   out_data_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                advance;
  logic                in_take;

  ges_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ges_event_logic u_logic (
    .item      (item_r),
    .cfg       (cfg),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  assign advance        = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall       = item_valid_r && !advance;
  assign in_take        = in_valid && !in_stall;
  assign item_valid_nxt = in_take || (item_valid_r && !advance);
  assign out_valid_nxt  = advance || (out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (advance) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) item_r <= in_data;
    if (advance) out_data_r <= result;
  end

  `ASSERT_RST(a_reset_clears_out, clk, !rst_n |=> !out_valid_r, "result valid after reset")
  `ASSERT_CLK(a_state_holds, clk, rst_n,
    !advance |=> $stable(state_r), "state moved without a transfer")
  `ASSERT_CLK(a_pad_source, clk, rst_n,
    state_r.current_pad == state_r.digital_pad || state_r.current_pad == state_r.analog_pad,
    "current pad matches neither source")
  `ASSERT_CLK(a_press_active, clk, rst_n,
    out_valid_r && out_data_r.press_event |-> out_data_r.activity, "press without activity")
  `ASSERT_CLK(a_report_excl, clk, rst_n,
    out_valid_r && !(out_data_r.press_event && out_data_r.release_event) ||
    !out_valid_r, "press and release reported together")

endmodule

[bench/ges_state_checker.sv]
// Checker of the gamepad event state tracker: watches the three channels, predicts every
// result from its own copy of the tracker state and configuration, and compares in order.
// Depends on ges_pkg.
`timescale 1ns / 1ps

module ges_state_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  ges_pkg::ges_in_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  ges_pkg::ges_out_t              out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ges_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ges_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             pending_reports,
  output int                             mismatch_count
);

  import ges_pkg::*;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam int HAT_UP    = 0;
  localparam int HAT_RIGHT = 1;
  localparam int HAT_DOWN  = 2;
  localparam int HAT_LEFT  = 3;

  ges_cfg_t   cfg_now;
  ges_state_t track;
  ges_out_t   expected_reports[$];
  bit         report_press;
  bit         report_release;
  logic [4:0] report_button;

  function automatic bit above_threshold(int v, bit held);
    int thr;
    thr = held ? int'(cfg_now.threshold_off) : int'(cfg_now.threshold_on);
    return v >= thr;
  endfunction

  function automatic void move_direction(logic [1:0] which, bit on, bit analog);
    logic [3:0] old_mask;
    logic [3:0] new_mask;
    old_mask = analog ? track.analog_pad : track.digital_pad;
    new_mask = old_mask;
    new_mask[which] = on;
    if (new_mask != old_mask) begin
      if (analog) track.analog_pad = new_mask;
      else track.digital_pad = new_mask;
      track.current_pad = new_mask;
      if (on) track.active_store = 1'b1;
    end
  endfunction

  function automatic void set_button(logic [5:0] which, bit on);
    if (which >= BUTTON_LIMIT) return;
    track.button_store[which[4:0]] = on;
    if (on) track.active_store = 1'b1;
    report_press   = on;
    report_release = !on;
    report_button  = which[4:0];
  endfunction

  function automatic void drive_stick(logic [1:0] pos_dir, logic [1:0] neg_dir, int v);
    bit held;
    held = track.analog_pad[pos_dir];
    if (above_threshold(v, held) != held) move_direction(pos_dir, !held, 1'b1);
    held = track.analog_pad[neg_dir];
    if (above_threshold(-v, held) != held) move_direction(neg_dir, !held, 1'b1);
  endfunction

  function automatic void drive_trigger(logic [4:0] bit_idx, int v);
    bit held;
    bit turned_on;
    held = track.button_store[bit_idx];
    turned_on = above_threshold(v, held);
    if (turned_on != held) set_button({1'b0, bit_idx}, turned_on);
  endfunction

  function automatic ges_out_t track_event(ges_in_t ev);
    ges_out_t r;
    int       v;
    v = $signed(ev.axis_value);
    report_press   = 1'b0;
    report_release = 1'b0;
    report_button  = '0;
    case (ev.func)
      FUNC_BUTTON: set_button(ev.event_index, ev.pressed);
      FUNC_PAD: begin
        if (ev.event_index <= {4'd0, DIR_RIGHT})
          move_direction(ev.event_index[1:0], ev.pressed, 1'b0);
      end
      FUNC_HAT: begin
        if (!cfg_now.is_gamepad) begin
          move_direction(DIR_UP, ev.hat_bits[HAT_UP], 1'b0);
          move_direction(DIR_DOWN, ev.hat_bits[HAT_DOWN], 1'b0);
          move_direction(DIR_LEFT, ev.hat_bits[HAT_LEFT], 1'b0);
          move_direction(DIR_RIGHT, ev.hat_bits[HAT_RIGHT], 1'b0);
        end
      end
      default: begin
        case (ev.event_index)
          AXIS_X: begin
            if (cfg_now.is_gamepad) track.stick_x_store = ev.axis_value;
            drive_stick(DIR_RIGHT, DIR_LEFT, v);
          end
          AXIS_Y: begin
            if (cfg_now.is_gamepad) track.stick_y_store = ev.axis_value;
            drive_stick(DIR_DOWN, DIR_UP, v);
          end
          AXIS_LT: if (cfg_now.is_gamepad) drive_trigger(cfg_now.trigger_left_bit, v);
          AXIS_RT: if (cfg_now.is_gamepad) drive_trigger(cfg_now.trigger_right_bit, v);
          default: ;
        endcase
      end
    endcase
    case (track.current_pad[1:0])
      2'b01:   r.y_position = POS_MIN;
      2'b10:   r.y_position = POS_MAX;
      default: r.y_position = POS_MID;
    endcase
    case (track.current_pad[3:2])
      2'b01:   r.x_position = POS_MIN;
      2'b10:   r.x_position = POS_MAX;
      default: r.x_position = POS_MID;
    endcase
    r.button_bits   = track.button_store;
    r.pad_bits      = track.current_pad;
    r.stick_x_out   = track.stick_x_store;
    r.stick_y_out   = track.stick_y_store;
    r.press_event   = report_press;
    r.release_event = report_release;
    r.event_button  = report_button;
    r.activity      = track.active_store;
    if (ev.clear_active) track.active_store = 1'b0;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    ges_out_t want;
    if (!rst_n) begin
      cfg_now = '{RST_THRESHOLD_ON, RST_THRESHOLD_OFF, RST_IS_GAMEPAD,
                  RST_TRIGGER_LEFT_BIT, RST_TRIGGER_RIGHT_BIT};
      track = '0;
      expected_reports.delete();
      mismatch_count = 0;
      pending_reports <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD_ON:      cfg_now.threshold_on = cfg_data;
          CFG_THRESHOLD_OFF:     cfg_now.threshold_off = cfg_data;
          CFG_IS_GAMEPAD:        cfg_now.is_gamepad = cfg_data[0];
          CFG_TRIGGER_LEFT_BIT:  cfg_now.trigger_left_bit = cfg_data[4:0];
          CFG_TRIGGER_RIGHT_BIT: cfg_now.trigger_right_bit = cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result expected none, got %h", $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("button_bits", want.button_bits, out_data.button_bits);
          compare_field("pad_bits", want.pad_bits, out_data.pad_bits);
          compare_field("x_position", want.x_position, out_data.x_position);
          compare_field("y_position", want.y_position, out_data.y_position);
          compare_field("stick_x_out", want.stick_x_out, out_data.stick_x_out);
          compare_field("stick_y_out", want.stick_y_out, out_data.stick_y_out);
          compare_field("press_event", want.press_event, out_data.press_event);
          compare_field("release_event", want.release_event, out_data.release_event);
          compare_field("event_button", want.event_button, out_data.event_button);
          compare_field("activity", want.activity, out_data.activity);
        end
      end
      if (in_valid && !in_stall) expected_reports.push_back(track_event(in_data));
      pending_reports <= expected_reports.size();
    end
  end

endmodule

[bench/tb.sv]
// Top of the gamepad event state tracker bench: clock, reset, configuration writes, directed
// and random events with random idling on both sides, watchdog and verdict.
// Depends on ges_pkg, gamepad_event_state_tracker and ges_state_checker.
`timescale 1ns / 1ps

module tb;

  import ges_pkg::*;

  localparam int IDLE_LIMIT     = 5000;
  localparam int SETTING_COUNT  = 6;
  localparam int EVENTS_PER_SET = 128;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  ges_in_t               in_data = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_stall;
  logic                  out_valid;
  ges_out_t              out_data;
  logic                  cfg_ready;
  int                    pending_reports;
  int                    mismatch_count;
  int                    sender_idle_pct = 13;
  int                    receiver_stall_pct = 57;
  int                    sent_events = 0;
  int                    quiet_cycles = 0;
  ges_cfg_t              active_cfg;

  gamepad_event_state_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ges_state_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending_reports (pending_reports),
    .mismatch_count  (mismatch_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("gamepad_event_state_tracker test failed");
      $finish;
    end
  end

  function automatic ges_in_t make_event(logic [1:0] func, logic [5:0] idx, logic pressed,
                                         logic [15:0] value, logic [3:0] hat, logic clr);
    ges_in_t ev;
    ev.func         = func;
    ev.event_index  = idx;
    ev.pressed      = pressed;
    ev.axis_value   = value;
    ev.hat_bits     = hat;
    ev.clear_active = clr;
    return ev;
  endfunction

  function automatic ges_in_t make_random_event();
    ges_in_t ev;
    int      thr;
    ev.func = 2'($urandom_range(3));
    if ($urandom_range(9) == 0) ev.event_index = 6'($urandom_range(63));
    else if (ev.func == FUNC_BUTTON) ev.event_index = 6'($urandom_range(31));
    else ev.event_index = 6'($urandom_range(3));
    ev.pressed      = 1'($urandom_range(1));
    ev.hat_bits     = 4'($urandom_range(15));
    ev.clear_active = ($urandom_range(9) == 0);
    case ($urandom_range(3))
      0: ev.axis_value = 16'($urandom);
      1: begin
        case ($urandom_range(3))
          0:       ev.axis_value = 16'h8000;
          1:       ev.axis_value = 16'h7FFF;
          2:       ev.axis_value = 16'h0000;
          default: ev.axis_value = 16'hFFFF;
        endcase
      end
      default: begin
        thr = $urandom_range(1) ? int'(active_cfg.threshold_on) : int'(active_cfg.threshold_off);
        thr = thr + int'($urandom_range(4)) - 2;
        if ($urandom_range(1)) thr = -thr;
        ev.axis_value = 16'(thr);
      end
    endcase
    return ev;
  endfunction

  function automatic bit event_is_ignored(ges_in_t ev);
    case (ev.func)
      FUNC_BUTTON: return ev.event_index >= BUTTON_LIMIT;
      FUNC_PAD:    return ev.event_index > {4'd0, DIR_RIGHT};
      FUNC_HAT:    return active_cfg.is_gamepad;
      default:     return (ev.event_index > AXIS_RT) ||
                          (ev.event_index >= AXIS_LT && !active_cfg.is_gamepad);
    endcase
  endfunction

  task automatic send_event(ges_in_t ev);
    if (sent_events < 380) begin
      sender_idle_pct    = 13;
      receiver_stall_pct = 57;
    end else if (sent_events < 760) begin
      sender_idle_pct    = 57;
      receiver_stall_pct = 13;
    end else begin
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
    sent_events++;
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports != 0);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_config(ges_cfg_t c);
    put_reg(CFG_THRESHOLD_ON, c.threshold_on);
    put_reg(CFG_THRESHOLD_OFF, c.threshold_off);
    put_reg(CFG_IS_GAMEPAD, CFG_DATA_W'(c.is_gamepad));
    put_reg(CFG_TRIGGER_LEFT_BIT, CFG_DATA_W'(c.trigger_left_bit));
    put_reg(CFG_TRIGGER_RIGHT_BIT, CFG_DATA_W'(c.trigger_right_bit));
    cfg_valid <= 1'b0;
    active_cfg = c;
  endtask

  initial begin
    ges_cfg_t settings[SETTING_COUNT];
    ges_in_t  ev;
    int       useful;
    settings[0] = '{RST_THRESHOLD_ON, RST_THRESHOLD_OFF, RST_IS_GAMEPAD,
                    RST_TRIGGER_LEFT_BIT, RST_TRIGGER_RIGHT_BIT};
    settings[1] = '{15'd0, 15'd0, 1'b1, 5'd0, 5'd31};
    settings[2] = '{15'd32767, 15'd32767, 1'b0, 5'd31, 5'd0};
    settings[3] = '{15'd1000, 15'd20000, 1'b1, 5'd5, 5'd5};
    settings[4] = '{15'd32767, 15'd0, 1'b1, 5'd31, 5'd30};
    settings[5] = '{15'($urandom), 15'($urandom), 1'($urandom), 5'($urandom), 5'($urandom)};
    active_cfg = settings[0];

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_event(make_event(FUNC_BUTTON, 6'd0, 1'b1, 16'h0000, 4'h0, 1'b0));
    send_event(make_event(FUNC_BUTTON, 6'd31, 1'b1, 16'hFFFF, 4'hF, 1'b0));
    send_event(make_event(FUNC_BUTTON, 6'd31, 1'b1, 16'h0000, 4'h0, 1'b0));
    send_event(make_event(FUNC_BUTTON, 6'd0, 1'b0, 16'h0000, 4'h0, 1'b0));
    send_event(make_event(FUNC_BUTTON, 6'd32, 1'b1, 16'h0000, 4'h0, 1'b0));
    send_event(make_event(FUNC_BUTTON, 6'd63, 1'b1, 16'h0000, 4'h0, 1'b1));
    send_event(make_event(FUNC_PAD, {4'd0, DIR_UP}, 1'b1, 16'h0000, 4'h0, 1'b0));
    send_event(make_event(FUNC_PAD, {4'd0, DIR_RIGHT}, 1'b1, 16'h0000, 4'h0, 1'b0));
    send_event(make_event(FUNC_PAD, {4'd0, DIR_RIGHT}, 1'b1, 16'h0000, 4'h0, 1'b0));
    send_event(make_event(FUNC_PAD, 6'd63, 1'b1, 16'h0000, 4'h0, 1'b0));
    send_event(make_event(FUNC_PAD, {4'd0, DIR_UP}, 1'b0, 16'h0000, 4'h0, 1'b0));
    send_event(make_event(FUNC_HAT, 6'd0, 1'b0, 16'h0000, 4'hF, 1'b0));
    send_event(make_event(FUNC_AXIS, AXIS_X, 1'b0, 16'h7FFF, 4'h0, 1'b0));
    send_event(make_event(FUNC_AXIS, AXIS_X, 1'b0, 16'h8000, 4'h0, 1'b0));
    send_event(make_event(FUNC_AXIS, AXIS_Y, 1'b0, 16'h0000, 4'h0, 1'b0));
    send_event(make_event(FUNC_AXIS, AXIS_Y, 1'b0, 16'h8000, 4'h0, 1'b0));
    send_event(make_event(FUNC_AXIS, AXIS_LT, 1'b0, 16'h7FFF, 4'h0, 1'b0));
    send_event(make_event(FUNC_AXIS, AXIS_LT, 1'b0, 16'h0000, 4'h0, 1'b0));
    send_event(make_event(FUNC_AXIS, AXIS_RT, 1'b0, 16'h8000, 4'h0, 1'b0));
    send_event(make_event(FUNC_AXIS, AXIS_RT, 1'b0, 16'h7FFF, 4'h0, 1'b1));
    send_event(make_event(FUNC_AXIS, 6'd63, 1'b1, 16'd1234, 4'h0, 1'b0));

    drain_reports();
    write_config('{RST_THRESHOLD_ON, RST_THRESHOLD_OFF, 1'b0, 5'd0, 5'd31});
    send_event(make_event(FUNC_HAT, 6'd0, 1'b0, 16'h0000, 4'hF, 1'b0));
    send_event(make_event(FUNC_HAT, 6'd0, 1'b0, 16'h0000, 4'h0, 1'b0));
    send_event(make_event(FUNC_HAT, 6'd0, 1'b0, 16'h0000, 4'h5, 1'b0));
    send_event(make_event(FUNC_AXIS, AXIS_LT, 1'b0, 16'h7FFF, 4'h0, 1'b0));
    send_event(make_event(FUNC_AXIS, AXIS_X, 1'b0, 16'd20000, 4'h0, 1'b0));

    for (int s = 0; s < SETTING_COUNT; s++) begin
      drain_reports();
      write_config(settings[s]);
      useful = 0;
      while (useful < EVENTS_PER_SET) begin
        ev = make_random_event();
        send_event(ev);
        if (!event_is_ignored(ev)) useful++;
      end
    end

    drain_reports();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("gamepad_event_state_tracker test passed");
    end else begin
      $display("gamepad_event_state_tracker test failed");
    end
    $finish;
  end

endmodule

[gamepad_event_state_tracker.f]
+incdir+rtl
rtl/ges_pkg.sv
rtl/ges_cfg_regs.sv
rtl/ges_event_logic.sv
rtl/gamepad_event_state_tracker.sv
bench/ges_state_checker.sv
bench/tb.sv
